>>> rtl/core/money_text_parser_unit_macros.svh
// Assertion helpers for the checker of the money text parser.
`ifndef MONEY_TEXT_PARSER_UNIT_MACROS_SVH
`define MONEY_TEXT_PARSER_UNIT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define MTP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds while reset is held.
`define MTP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/mtp_pkg.sv
package mtp_pkg;

    localparam int SYMBOL_BYTES = 4;
    localparam int VALUE_BITS   = 32;
    localparam int SYM_CAP      = (SYMBOL_BYTES < 4) ? SYMBOL_BYTES : 4;
    localparam int IDX_W        = (SYMBOL_BYTES > 1) ? $clog2(SYMBOL_BYTES) : 1;
    localparam int CNT_W        = $clog2(SYMBOL_BYTES + 1);
    localparam int ACC_W        = VALUE_BITS + 4;

    localparam int CHAR_W     = 8;
    localparam int AMOUNT_W   = 32;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FRAC_W     = 4;
    localparam int LEN_W      = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAC_DIGITS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIMAL_CHAR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_CHAR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLUS_CHAR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENCY_TEXT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENCY_LEN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MINUS_TEXT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MINUS_LEN     = 3'd7;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FORMAT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    // Error latch bits.
    localparam logic [1:0] ERR_FORMAT = 2'b01;
    localparam logic [1:0] ERR_OVF    = 2'b10;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_OPEN   = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_FIVE   = 8'h35;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

    localparam logic [FRAC_W-1:0] FRAC_MAX     = 4'd9;
    localparam logic [FRAC_W-1:0] FRAC_DEFAULT = 4'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic want_byte;   // the current phase consumes text bytes
        logic sym_minus;   // compare against the minus string, else currency
        logic pop;         // drop the byte at the head of the buffer
        logic match_adv;   // current byte extends a partial symbol match
        logic match_done;  // current byte completes the symbol
        logic match_fail;  // rewind to replay the held bytes
        logic acc_digit;   // accumulator times ten plus the current digit
        logic acc_round;   // accumulator plus one
        logic pad_step;    // accumulator times ten for a missing fraction digit
        logic set_point;
        logic set_neg;
        logic set_format;
        logic finish;      // load the result register and clear the parse state
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic has_byte;
        logic out_free;
        logic is_ws;
        logic is_digit;
        logic is_ge5;
        logic is_nul;
        logic is_zero_ch;
        logic is_close;
        logic is_open;
        logic is_plus;
        logic is_dec;
        logic is_grp;
        logic sym_hit;
        logic sym_last;
        logic frac_lt;
        logic point_seen;
    } t_stat;

endpackage

>>> rtl/core/mtp_char_if.sv
interface mtp_char_if import mtp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

>>> rtl/core/mtp_result_if.sv
interface mtp_result_if import mtp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [AMOUNT_W-1:0] amount;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output amount, output status, input ready);
    modport sink (input valid, input amount, input status, output ready);
endinterface

>>> rtl/core/mtp_cfg_if.sv
interface mtp_cfg_if import mtp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/money_text_parser_unit.sv
// Channel    Dir  Handshake      Payload
// i_char     in   valid/ready    char_code[7:0], byte 0 ends the text
// o_result   out  valid/ready    amount[31:0] signed, status[1:0]
// i_cfg      in   valid/ready    index[2:0], data[31:0], always ready
//
// A byte is taken into the buffer in one cycle and parsed in the next;
// no new byte is taken while an unparsed byte waits in the buffer. After a
// failed partial symbol match the buffer replays the held bytes from its
// head; a fraction shorter than frac_digits is padded by one times-ten step per missing digit.
// Reset is synchronous and active low and restores the default symbols.
// The result sits in an output register; a terminator waits only while a
// previous result has not been taken.
module money_text_parser_unit import mtp_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    mtp_char_if.sink          i_char,
    mtp_cfg_if.sink           i_cfg,
    mtp_result_if.source      o_result
);

    t_cmd  cmd;
    t_stat stat;

    mtp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    mtp_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_char_valid (i_char.valid),
        .o_char_ready (i_char.ready),
        .i_char_code  (i_char.char_code),
        .i_cfg_valid  (i_cfg.valid),
        .o_cfg_ready  (i_cfg.ready),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .o_res_valid  (o_result.valid),
        .i_res_ready  (o_result.ready),
        .o_amount     (o_result.amount),
        .o_status     (o_result.status)
    );

endmodule

>>> rtl/core/mtp_ctrl.sv
module mtp_ctrl import mtp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_WS1,
        S_CUR1,
        S_SIGN,
        S_SIGNALT,
        S_WS2,
        S_CUR2,
        S_NUM,
        S_PAD,
        S_EXCESS,
        S_TRAIL,
        S_BAD
    } t_state;

    t_state r_state, n_state;
    logic   r_pad_trail, n_pad_trail;
    t_cmd   cmd;

    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        n_pad_trail = r_pad_trail;
        cmd.want_byte = (r_state != S_PAD);
        cmd.sym_minus = (r_state == S_SIGN);

        if (r_state == S_PAD) begin
            if (i_stat.frac_lt) begin
                cmd.pad_step = 1'b1;
            end else begin
                n_state = r_pad_trail ? S_TRAIL : S_EXCESS;
            end
        end else if (i_stat.has_byte) begin
            unique case (r_state) inside
                S_WS1, S_WS2: begin
                    if (i_stat.is_ws) begin
                        cmd.pop = 1'b1;
                    end else begin
                        n_state = (r_state == S_WS1) ? S_CUR1 : S_CUR2;
                    end
                end
                S_CUR1, S_SIGN, S_CUR2: begin
                    if (i_stat.sym_hit) begin
                        if (i_stat.sym_last) begin
                            cmd.match_done = 1'b1;
                            cmd.set_neg    = (r_state == S_SIGN);
                            n_state = (r_state == S_CUR1) ? S_SIGN :
                                      (r_state == S_SIGN) ? S_WS2 : S_NUM;
                        end else begin
                            cmd.match_adv = 1'b1;
                        end
                    end else begin
                        // Held bytes are replayed from the head of the buffer.
                        cmd.match_fail = 1'b1;
                        n_state = (r_state == S_CUR1) ? S_SIGN :
                                  (r_state == S_SIGN) ? S_SIGNALT : S_NUM;
                    end
                end
                S_SIGNALT: begin
                    n_state = S_WS2;
                    if (i_stat.is_open) begin
                        cmd.set_neg = 1'b1;
                        cmd.pop     = 1'b1;
                    end else if (i_stat.is_plus) begin
                        cmd.pop = 1'b1;
                    end
                end
                S_NUM: begin
                    if (i_stat.is_digit && (!i_stat.point_seen || i_stat.frac_lt)) begin
                        cmd.acc_digit = 1'b1;
                        cmd.pop       = 1'b1;
                    end else if (i_stat.is_dec && !i_stat.point_seen) begin
                        cmd.set_point = 1'b1;
                        cmd.pop       = 1'b1;
                    end else if (i_stat.is_grp) begin
                        cmd.pop = 1'b1;
                    end else if (i_stat.is_digit) begin
                        cmd.acc_round = i_stat.is_ge5;
                        cmd.pop       = 1'b1;
                        n_state       = S_PAD;
                        n_pad_trail   = 1'b0;
                    end else begin
                        // The byte stays and is looked at again as trailing text.
                        n_state     = S_PAD;
                        n_pad_trail = 1'b1;
                    end
                end
                S_EXCESS: begin
                    if (i_stat.is_digit) begin
                        cmd.pop = 1'b1;
                    end else begin
                        n_state = S_TRAIL;
                    end
                end
                S_TRAIL: begin
                    if (i_stat.is_nul) begin
                        if (i_stat.out_free) begin
                            cmd.finish = 1'b1;
                            n_state    = S_WS1;
                        end
                    end else if (i_stat.is_ws || i_stat.is_zero_ch || i_stat.is_close) begin
                        cmd.pop = 1'b1;
                    end else begin
                        cmd.set_format = 1'b1;
                        cmd.pop        = 1'b1;
                        n_state        = S_BAD;
                    end
                end
                S_BAD: begin
                    if (i_stat.is_nul) begin
                        if (i_stat.out_free) begin
                            cmd.finish = 1'b1;
                            n_state    = S_WS1;
                        end
                    end else begin
                        cmd.pop = 1'b1;
                    end
                end
                default: begin
                    n_state = S_WS1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WS1;
            r_pad_trail <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pad_trail <= n_pad_trail;
        end
    end

    assign o_cmd = cmd;

endmodule

>>> rtl/core/mtp_dpath.sv
module mtp_dpath import mtp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_char_valid,
    output logic                  o_char_ready,
    input  logic [CHAR_W-1:0]     i_char_code,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic [AMOUNT_W-1:0]   o_amount,
    output logic [STATUS_W-1:0]   o_status
);

    localparam logic [ACC_W-1:0] VAL_MAX = ACC_W'({(VALUE_BITS-1){1'b1}});

    // Number of bytes of a symbol: empty first byte selects the default,
    // a zero byte ends it early.
    function automatic logic [LEN_W-1:0] f_sym_len(input logic [31:0] text,
                                                   input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] n;
        logic [LEN_W-1:0] res;
        if (len == '0) begin
            n = LEN_W'(1);
        end else if (len > LEN_W'(SYM_CAP)) begin
            n = LEN_W'(SYM_CAP);
        end else begin
            n = len;
        end
        res = n;
        for (int i = SYM_CAP - 1; i >= 1; i--) begin
            if ((LEN_W'(i) < n) && (text[8*i +: 8] == CH_NUL)) begin
                res = LEN_W'(i);
            end
        end
        if (text[7:0] == CH_NUL) begin
            res = LEN_W'(1);
        end
        return res;
    endfunction

    // Configuration registers.
    logic [FRAC_W-1:0] r_frac_digits;
    logic [CHAR_W-1:0] r_decimal_char, r_group_char, r_plus_char;
    logic [31:0]       r_currency_text, r_minus_text;
    logic [LEN_W-1:0]  r_currency_len, r_minus_len;

    // Parse state.
    logic [CHAR_W-1:0]     r_buf [SYMBOL_BYTES];
    logic [CHAR_W-1:0]     n_buf [SYMBOL_BYTES];
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [IDX_W-1:0]      r_match, n_match;
    logic [VALUE_BITS-1:0] r_accum, n_accum;
    logic [FRAC_W-1:0]     r_frac, n_frac;
    logic                  r_point, n_point;
    logic                  r_neg, n_neg;
    logic [1:0]            r_err, n_err;

    logic                  r_out_valid;
    logic [AMOUNT_W-1:0]   r_amount;
    logic [STATUS_W-1:0]   r_status;

    logic [CHAR_W-1:0]     cur;
    logic                  has_byte;
    logic                  accept;
    logic                  out_free;
    logic [FRAC_W-1:0]     eff_frac;
    logic [CHAR_W-1:0]     dec_ch, grp_ch, pls_ch;
    logic [31:0]           sym_text;
    logic [31:0]           sym_shift;
    logic [LEN_W-1:0]      sym_len_cfg;
    logic [LEN_W-1:0]      sym_n;
    logic [CHAR_W-1:0]     sym_byte;
    logic [CHAR_W-1:0]     sym_deflt;
    logic                  is_digit;
    logic [ACC_W-1:0]      acc_base, acc_wide;
    logic [3:0]            addend;
    logic                  acc_op;
    logic [VALUE_BITS-1:0] mag;
    logic [CNT_W-1:0]      shift;

    assign has_byte = (r_cnt > CNT_W'(r_match));
    assign cur      = r_buf[r_match];
    assign accept   = i_char_valid && o_char_ready;
    assign out_free = !r_out_valid || i_res_ready;
    assign eff_frac = (r_frac_digits > FRAC_MAX) ? FRAC_DEFAULT : r_frac_digits;
    assign dec_ch   = (r_decimal_char == CH_NUL) ? CH_DOT : r_decimal_char;
    assign grp_ch   = (r_group_char == CH_NUL) ? CH_COMMA : r_group_char;
    assign pls_ch   = (r_plus_char == CH_NUL) ? CH_PLUS : r_plus_char;
    assign is_digit = (cur >= CH_ZERO) && (cur <= CH_NINE);

    assign sym_text    = i_cmd.sym_minus ? r_minus_text : r_currency_text;
    assign sym_len_cfg = i_cmd.sym_minus ? r_minus_len : r_currency_len;
    assign sym_deflt   = i_cmd.sym_minus ? CH_MINUS : CH_DOLLAR;
    assign sym_n       = f_sym_len(sym_text, sym_len_cfg);
    assign sym_shift   = sym_text >> {r_match, 3'b000};
    assign sym_byte    = (sym_text[7:0] == CH_NUL) ? sym_deflt : sym_shift[7:0];

    always_comb begin
        o_stat            = '0;
        o_stat.has_byte   = has_byte;
        o_stat.out_free   = out_free;
        o_stat.is_ws      = (cur == CH_SPACE) || ((cur >= CH_TAB) && (cur <= CH_CR));
        o_stat.is_digit   = is_digit;
        o_stat.is_ge5     = (cur >= CH_FIVE);
        o_stat.is_nul     = (cur == CH_NUL);
        o_stat.is_zero_ch = (cur == CH_ZERO);
        o_stat.is_close   = (cur == CH_CLOSE);
        o_stat.is_open    = (cur == CH_OPEN);
        o_stat.is_plus    = (cur == pls_ch);
        o_stat.is_dec     = (cur == dec_ch);
        o_stat.is_grp     = (cur == grp_ch);
        o_stat.sym_hit    = (LEN_W'(r_match) < sym_n) && (cur == sym_byte);
        o_stat.sym_last   = ((LEN_W'(r_match) + LEN_W'(1)) == sym_n);
        o_stat.frac_lt    = (r_frac < eff_frac);
        o_stat.point_seen = r_point;
    end

    assign o_char_ready = i_cmd.want_byte && !has_byte;
    assign o_cfg_ready  = 1'b1;

    // Multiply-add unit: times ten plus a digit, times ten for padding, or plus one for rounding.
    assign acc_op   = i_cmd.acc_digit || i_cmd.pad_step || i_cmd.acc_round;
    assign addend   = i_cmd.acc_digit ? 4'(cur - CH_ZERO) :
                      (i_cmd.acc_round ? 4'd1 : 4'd0);
    assign acc_base = i_cmd.acc_round ? ACC_W'(r_accum) :
                      ((ACC_W'(r_accum) << 3) + (ACC_W'(r_accum) << 1));
    assign acc_wide = acc_base + ACC_W'(addend);

    assign mag = r_neg ? (VALUE_BITS'(0) - r_accum) : r_accum;

    always_comb begin
        logic [CNT_W:0] src;
        n_buf   = r_buf;
        n_cnt   = r_cnt;
        n_match = r_match;
        n_accum = r_accum;
        n_frac  = r_frac;
        n_point = r_point;
        n_neg   = r_neg;
        n_err   = r_err;
        shift   = '0;

        if (i_cmd.pop) begin
            shift = CNT_W'(1);
        end else if (i_cmd.match_done) begin
            shift = CNT_W'(r_match) + CNT_W'(1);
        end

        for (int i = 0; i < SYMBOL_BYTES; i++) begin
            src = (CNT_W + 1)'(i) + (CNT_W + 1)'(shift);
            if (src < (CNT_W + 1)'(SYMBOL_BYTES)) begin
                n_buf[i] = r_buf[src[IDX_W-1:0]];
            end
        end
        n_cnt = r_cnt - shift;

        if (i_cmd.match_adv) begin
            n_match = r_match + IDX_W'(1);
        end
        if (i_cmd.match_done || i_cmd.match_fail) begin
            n_match = '0;
        end

        if (accept) begin
            n_buf[r_cnt[IDX_W-1:0]] = i_char_code;
            n_cnt = r_cnt + CNT_W'(1);
        end

        if (acc_op) begin
            n_accum = acc_wide[VALUE_BITS-1:0];
            if (acc_wide > VAL_MAX) begin
                n_err = r_err | ERR_OVF;
            end
        end
        if (i_cmd.pad_step || (i_cmd.acc_digit && r_point)) begin
            n_frac = r_frac + FRAC_W'(1);
        end
        if (i_cmd.set_point) begin
            n_point = 1'b1;
        end
        if (i_cmd.set_neg) begin
            n_neg = 1'b1;
        end
        if (i_cmd.set_format) begin
            n_err = r_err | ERR_FORMAT;
        end

        if (i_cmd.finish) begin
            n_cnt   = '0;
            n_match = '0;
            n_accum = '0;
            n_frac  = '0;
            n_point = 1'b0;
            n_neg   = 1'b0;
            n_err   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_digits   <= FRAC_DEFAULT;
            r_decimal_char  <= CH_DOT;
            r_group_char    <= CH_COMMA;
            r_plus_char     <= CH_PLUS;
            r_currency_text <= 32'(CH_DOLLAR);
            r_currency_len  <= LEN_W'(1);
            r_minus_text    <= 32'(CH_MINUS);
            r_minus_len     <= LEN_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAC_DIGITS:   r_frac_digits   <= i_cfg_data[FRAC_W-1:0];
                CFG_DECIMAL_CHAR:  r_decimal_char  <= i_cfg_data[CHAR_W-1:0];
                CFG_GROUP_CHAR:    r_group_char    <= i_cfg_data[CHAR_W-1:0];
                CFG_PLUS_CHAR:     r_plus_char     <= i_cfg_data[CHAR_W-1:0];
                CFG_CURRENCY_TEXT: r_currency_text <= i_cfg_data[31:0];
                CFG_CURRENCY_LEN:  r_currency_len  <= i_cfg_data[LEN_W-1:0];
                CFG_MINUS_TEXT:    r_minus_text    <= i_cfg_data[31:0];
                CFG_MINUS_LEN:     r_minus_len     <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_match     <= '0;
            r_accum     <= '0;
            r_frac      <= '0;
            r_point     <= 1'b0;
            r_neg       <= 1'b0;
            r_err       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_match <= n_match;
            r_accum <= n_accum;
            r_frac  <= n_frac;
            r_point <= n_point;
            r_neg   <= n_neg;
            r_err   <= n_err;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Byte buffer and result payload carry no reset.
    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        if (i_cmd.finish) begin
            if ((r_err & ERR_FORMAT) != '0) begin
                r_status <= ST_FORMAT;
                r_amount <= '0;
            end else begin
                r_status <= ((r_err & ERR_OVF) != '0) ? ST_OVERFLOW : ST_OK;
                r_amount <= AMOUNT_W'($signed(mag));
            end
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_amount    = r_amount;
    assign o_status    = r_status;

endmodule

>>> rtl/core/mtp_checker.sv
`include "money_text_parser_unit_macros.svh"

module mtp_checker import mtp_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [AMOUNT_W-1:0] i_amount,
    input logic [STATUS_W-1:0] i_status
);

    // Only three status codes exist.
    `MTP_ASSERT(a_status_code, i_clk, i_rst_n, i_out_valid |-> (i_status == ST_OK || i_status == ST_FORMAT || i_status == ST_OVERFLOW), "undefined status code")

    // A badly formed text always reports a zero amount.
    `MTP_ASSERT(a_bad_zero, i_clk, i_rst_n, (i_out_valid && i_status == ST_FORMAT) |-> (i_amount == '0), "bad format with nonzero amount")

    // A result that is not taken stays unchanged.
    `MTP_ASSERT(a_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_amount) && $stable(i_status)), "result changed while stalled")

    // No result is offered right after reset.
    `MTP_ASSERT_ALWAYS(a_reset_idle, i_clk, $past(!i_rst_n) |-> !i_out_valid, "result valid after reset")

endmodule

bind money_text_parser_unit mtp_checker u_mtp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_amount    (o_result.amount),
    .i_status    (o_result.status)
);

>>> tb/sv/money_text_parser_unit_test.sv
`timescale 1ns / 100ps

module money_text_parser_unit_test;
    import mtp_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_GAP       = 13;
    localparam logic [63:0] VAL_MASK = ((64'd1 << (VALUE_BITS - 1)) << 1) - 64'd1;
    localparam logic [63:0] VAL_MAX  = VAL_MASK >> 1;

    typedef enum logic [3:0] {
        PS_LEAD_WS, PS_LEAD_CUR, PS_SIGN_STR, PS_SIGN_ALT, PS_MID_WS,
        PS_MID_CUR, PS_DIGITS, PS_EXCESS, PS_TRAIL, PS_JUNK
    } parse_step_e;

    typedef struct packed {
        logic [AMOUNT_W-1:0] amount;
        logic [STATUS_W-1:0] status;
    } money_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mtp_char_if   char_bus ();
    mtp_cfg_if    cfg_bus ();
    mtp_result_if result_bus ();

    money_text_parser_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (char_bus),
        .i_cfg    (cfg_bus),
        .o_result (result_bus)
    );

    always #1 i_clk = ~i_clk;

    // Register copies used by the predictor.
    logic [FRAC_W-1:0]     cf_frac;
    logic [CHAR_W-1:0]     cf_decimal;
    logic [CHAR_W-1:0]     cf_group;
    logic [CHAR_W-1:0]     cf_plus;
    logic [CFG_DATA_W-1:0] cf_cur_text;
    logic [LEN_W-1:0]      cf_cur_len;
    logic [CFG_DATA_W-1:0] cf_minus_text;
    logic [LEN_W-1:0]      cf_minus_len;

    // Parse state of the predictor.
    parse_step_e money_phase;
    logic [63:0] money_accum;
    int          money_frac_cnt;
    bit          money_point;
    bit          money_neg;
    int          money_match;
    logic [7:0]  money_hold [0:3];
    logic [1:0]  money_err;

    money_result_t awaited_amounts[$];
    logic [7:0]    draft[$];

    int fail_count      = 0;
    int cycle_count     = 0;
    int hold_off_cycles = 0;
    bit source_lazy     = 1'b0;
    bit sink_lazy       = 1'b0;

    function automatic logic [7:0] or_default(logic [7:0] c, logic [7:0] deflt);
        return (c == CH_NUL) ? deflt : c;
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic int scaled_digits();
        return (cf_frac > FRAC_MAX) ? int'(FRAC_DEFAULT) : int'(cf_frac);
    endfunction

    // Effective bytes of a symbol register pair; returns the symbol length.
    function automatic int load_symbol(logic [31:0] text, logic [2:0] len,
                                       logic [7:0] deflt, output logic [3:0][7:0] sym);
        int n;
        int cnt;
        int i;
        sym = '0;
        if (text[7:0] == CH_NUL) begin
            sym[0] = deflt;
            cnt = 1;
        end else begin
            n = (len == 0) ? 1 : int'(len);
            if (n > SYM_CAP) n = SYM_CAP;
            cnt = n;
            // Walking down leaves cnt at the first zero byte.
            for (i = n - 1; i >= 0; i--) begin
                sym[i] = text[8*i +: 8];
                if (sym[i] == CH_NUL) cnt = i;
            end
        end
        return cnt;
    endfunction

    function automatic void clear_parse();
        money_phase    = PS_LEAD_WS;
        money_accum    = '0;
        money_frac_cnt = 0;
        money_point    = 1'b0;
        money_neg      = 1'b0;
        money_match    = 0;
        money_err      = '0;
    endfunction

    function automatic void accum_step(int unsigned k, logic [63:0] d);
        if ((money_err & ERR_OVF) == 0) begin
            if (k == 10 ? (money_accum > (VAL_MAX - d) / 10) : (money_accum > VAL_MAX - d))
                money_err = money_err | ERR_OVF;
        end
        money_accum = (money_accum * k + d) & VAL_MASK;
    endfunction

    function automatic void pad_fraction();
        while (money_frac_cnt < scaled_digits()) begin
            accum_step(10, 64'd0);
            money_frac_cnt++;
        end
    endfunction

    function automatic void close_amount();
        money_result_t r;
        logic [63:0]   v;
        if ((money_err & ERR_FORMAT) != 0) begin
            r.status = ST_FORMAT;
            v = '0;
        end else begin
            r.status = ((money_err & ERR_OVF) != 0) ? ST_OVERFLOW : ST_OK;
            v = money_neg ? ((64'd0 - money_accum) & VAL_MASK) : (money_accum & VAL_MASK);
            if (v[VALUE_BITS-1]) v = v | ~VAL_MASK;
        end
        r.amount = v[AMOUNT_W-1:0];
        awaited_amounts.push_back(r);
        clear_parse();
    endfunction

    // Bytes that move to a new phase or are replayed after a failed symbol
    // match go back to the front of the work list, in the original order.
    function automatic void parse_money_byte(logic [7:0] b);
        logic [7:0]      work[$];
        logic [7:0]      c;
        logic [3:0][7:0] sym;
        logic [7:0]      dec_ch;
        logic [7:0]      grp_ch;
        logic [7:0]      pls_ch;
        int              n;
        int              i;
        bit              dig;
        dec_ch = or_default(cf_decimal, CH_DOT);
        grp_ch = or_default(cf_group, CH_COMMA);
        pls_ch = or_default(cf_plus, CH_PLUS);
        work.push_back(b);
        while (work.size() > 0) begin
            c = work.pop_front();
            dig = (c >= CH_ZERO) && (c <= CH_NINE);
            case (money_phase)
                PS_LEAD_WS, PS_MID_WS: begin
                    if (!is_space(c)) begin
                        money_phase = (money_phase == PS_LEAD_WS) ? PS_LEAD_CUR : PS_MID_CUR;
                        work.push_front(c);
                    end
                end
                PS_LEAD_CUR, PS_SIGN_STR, PS_MID_CUR: begin
                    if (money_phase == PS_SIGN_STR)
                        n = load_symbol(cf_minus_text, cf_minus_len, CH_MINUS, sym);
                    else
                        n = load_symbol(cf_cur_text, cf_cur_len, CH_DOLLAR, sym);
                    if (money_match < n && c == sym[money_match]) begin
                        if (money_match + 1 == n) begin
                            money_match = 0;
                            if (money_phase == PS_SIGN_STR) begin
                                money_neg = 1'b1;
                                money_phase = PS_MID_WS;
                            end else begin
                                money_phase = (money_phase == PS_LEAD_CUR) ? PS_SIGN_STR
                                                                           : PS_DIGITS;
                            end
                        end else begin
                            money_hold[money_match] = c;
                            money_match++;
                        end
                    end else begin
                        work.push_front(c);
                        for (i = money_match - 1; i >= 0; i--) work.push_front(money_hold[i]);
                        money_match = 0;
                        case (money_phase)
                            PS_LEAD_CUR: money_phase = PS_SIGN_STR;
                            PS_SIGN_STR: money_phase = PS_SIGN_ALT;
                            default:     money_phase = PS_DIGITS;
                        endcase
                    end
                end
                PS_SIGN_ALT: begin
                    money_phase = PS_MID_WS;
                    if (c == CH_OPEN) money_neg = 1'b1;
                    else if (c != pls_ch) work.push_front(c);
                end
                PS_DIGITS: begin
                    if (dig && (!money_point || money_frac_cnt < scaled_digits())) begin
                        accum_step(10, 64'(c - CH_ZERO));
                        if (money_point) money_frac_cnt++;
                    end else if (c == dec_ch && !money_point) begin
                        money_point = 1'b1;
                    end else if (c == grp_ch) begin
                    end else if (dig) begin
                        if (c >= CH_FIVE) accum_step(1, 64'd1);
                        pad_fraction();
                        money_phase = PS_EXCESS;
                    end else begin
                        pad_fraction();
                        money_phase = PS_TRAIL;
                        work.push_front(c);
                    end
                end
                PS_EXCESS: begin
                    if (!dig) begin
                        money_phase = PS_TRAIL;
                        work.push_front(c);
                    end
                end
                PS_TRAIL: begin
                    if (c == CH_NUL) begin
                        close_amount();
                    end else if (!(is_space(c) || c == CH_ZERO || c == CH_CLOSE)) begin
                        money_err = money_err | ERR_FORMAT;
                        money_phase = PS_JUNK;
                    end
                end
                default: begin
                    if (c == CH_NUL) close_amount();
                end
            endcase
        end
    endfunction

    function automatic logic [7:0] pick_space();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
    endfunction

    // Appends a symbol, now and then only a leading part of it.
    function automatic void draft_symbol(logic [3:0][7:0] sym, int n);
        int m;
        int i;
        m = n;
        if (n > 1 && $urandom_range(0, 3) == 0) m = $urandom_range(1, n - 1);
        for (i = 0; i < m; i++) draft.push_back(sym[i]);
    endfunction

    // Builds one terminated money text for the current register settings.
    function automatic void make_money_text();
        logic [3:0][7:0] cur_sym;
        logic [3:0][7:0] neg_sym;
        int              n_cur;
        int              n_neg;
        int              n_dig;
        int              roll;
        int              i;
        draft.delete();
        n_cur = load_symbol(cf_cur_text, cf_cur_len, CH_DOLLAR, cur_sym);
        n_neg = load_symbol(cf_minus_text, cf_minus_len, CH_MINUS, neg_sym);
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            n_dig = $urandom_range(0, 8);
            for (i = 0; i < n_dig; i++) draft.push_back(8'($urandom_range(1, 255)));
        end else begin
            repeat ($urandom_range(0, 2)) draft.push_back(pick_space());
            if ($urandom_range(0, 2) == 0) draft_symbol(cur_sym, n_cur);
            case ($urandom_range(0, 3))
                1: draft_symbol(neg_sym, n_neg);
                2: draft.push_back(CH_OPEN);
                3: draft.push_back(or_default(cf_plus, CH_PLUS));
                default: ;
            endcase
            repeat ($urandom_range(0, 1)) draft.push_back(pick_space());
            if ($urandom_range(0, 2) == 0) draft_symbol(cur_sym, n_cur);
            n_dig = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 6);
            for (i = 0; i < n_dig; i++) begin
                draft.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                if ($urandom_range(0, 5) == 0) draft.push_back(or_default(cf_group, CH_COMMA));
            end
            if ($urandom_range(0, 1) == 0) begin
                draft.push_back(or_default(cf_decimal, CH_DOT));
                n_dig = $urandom_range(0, scaled_digits() + 2);
                for (i = 0; i < n_dig; i++) draft.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            end
            repeat ($urandom_range(0, 2)) begin
                case ($urandom_range(0, 2))
                    0: draft.push_back(CH_CLOSE);
                    1: draft.push_back(pick_space());
                    default: draft.push_back(CH_ZERO);
                endcase
            end
            if (roll < 25)
                draft.insert($urandom_range(0, draft.size()), 8'($urandom_range(1, 255)));
        end
        draft.push_back(CH_NUL);
    endfunction

    function automatic logic [7:0] random_symbol_byte();
        logic [7:0] b;
        b = 8'($urandom_range(33, 126));
        while (b >= CH_ZERO && b <= CH_NINE) b = 8'($urandom_range(33, 126));
        return b;
    endfunction

    function automatic logic [7:0] random_setting_char();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return CH_NUL;
        if (r == 1) return 8'($urandom_range(0, 255));
        return random_symbol_byte();
    endfunction

    // Valid stays high after a request is taken, so a back-to-back byte
    // never needs a low and a high in the same step.
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = source_lazy ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            char_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= c;
        @(posedge i_clk);
        while (!char_bus.ready) @(posedge i_clk);
        parse_money_byte(c);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_char(s[i]);
        send_char(CH_NUL);
    endtask

    task automatic send_draft();
        int i;
        for (i = 0; i < draft.size(); i++) send_char(draft[i]);
    endtask

    task automatic wait_results_drained();
        char_bus.valid <= 1'b0;
        while (awaited_amounts.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        case (idx)
            CFG_FRAC_DIGITS:   cf_frac       = val[FRAC_W-1:0];
            CFG_DECIMAL_CHAR:  cf_decimal    = val[CHAR_W-1:0];
            CFG_GROUP_CHAR:    cf_group      = val[CHAR_W-1:0];
            CFG_PLUS_CHAR:     cf_plus       = val[CHAR_W-1:0];
            CFG_CURRENCY_TEXT: cf_cur_text   = val;
            CFG_CURRENCY_LEN:  cf_cur_len    = val[LEN_W-1:0];
            CFG_MINUS_TEXT:    cf_minus_text = val;
            default:           cf_minus_len  = val[LEN_W-1:0];
        endcase
    endtask

    // Narrow registers get random upper data bits, which must be ignored.
    task automatic apply_settings(input logic [FRAC_W-1:0] frac, input logic [7:0] dec_ch,
                                  input logic [7:0] grp_ch, input logic [7:0] pls_ch,
                                  input logic [31:0] cur, input logic [LEN_W-1:0] cur_len,
                                  input logic [31:0] neg, input logic [LEN_W-1:0] neg_len);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_FRAC_DIGITS, (32'($urandom) & ~32'hF) | 32'(frac));
        write_reg(CFG_DECIMAL_CHAR, (32'($urandom) & ~32'hFF) | 32'(dec_ch));
        write_reg(CFG_GROUP_CHAR, (32'($urandom) & ~32'hFF) | 32'(grp_ch));
        write_reg(CFG_PLUS_CHAR, (32'($urandom) & ~32'hFF) | 32'(pls_ch));
        write_reg(CFG_CURRENCY_TEXT, cur);
        write_reg(CFG_CURRENCY_LEN, (32'($urandom) & ~32'h7) | 32'(cur_len));
        write_reg(CFG_MINUS_TEXT, neg);
        write_reg(CFG_MINUS_LEN, (32'($urandom) & ~32'h7) | 32'(neg_len));
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic run_money_texts(input int byte_quota);
        int sent;
        sent = 0;
        while (sent < byte_quota) begin
            source_lazy = ($urandom_range(0, 9) < 7);
            sink_lazy   = ($urandom_range(0, 9) < 7);
            make_money_text();
            sent += draft.size();
            send_draft();
        end
    endtask

    task automatic test_directed_defaults();
        source_lazy = 1'b0;
        sink_lazy   = 1'b0;
        send_text("");
        send_text(" $-1,2.5");
        send_text("(7.125)");
        send_text("+.994 0");
        send_text("21474836.48");
        send_char(CH_NINE);
        send_char(8'hFF);
        send_char(CH_NUL);
    endtask

    task automatic test_register_settings();
        logic [31:0] cur;
        logic [31:0] neg;
        int          phase;
        int          i;
        apply_settings(4'd0, CH_DOT, CH_COMMA, CH_PLUS, 32'h24, 3'd1, 32'h2D, 3'd1);
        run_money_texts(180);
        // Multi-byte symbols that share no first byte with the digits.
        apply_settings(FRAC_MAX, CH_COMMA, CH_DOT, 8'h7E, 32'h0044_5355, 3'd3,
                       32'h0067_656E, 3'd3);
        run_money_texts(180);
        // Zero characters and symbols fall back to their defaults, and so does the fraction count of 15.
        apply_settings(4'd15, CH_NUL, CH_NUL, CH_NUL, 32'h0, 3'd0, 32'h0, 3'd0);
        run_money_texts(180);
        apply_settings(4'd4, 8'hFF, 8'h80, 8'h01, 32'hFFFF_FFFF, 3'd7, 32'h002D_2D2D, 3'd4);
        run_money_texts(180);
        apply_settings(4'd3, 8'h27, CH_SPACE, CH_PLUS, 32'h0000_5845, 3'd4,
                       32'h2D2D_2D2D, 3'd2);
        run_money_texts(180);
        for (phase = 0; phase < 5; phase++) begin
            for (i = 0; i < 4; i++) begin
                cur[8*i +: 8] = random_symbol_byte();
                neg[8*i +: 8] = random_symbol_byte();
            end
            apply_settings(4'($urandom_range(0, 15)), random_setting_char(),
                           random_setting_char(), random_setting_char(), cur,
                           3'($urandom_range(0, 7)), neg, 3'($urandom_range(0, 7)));
            run_money_texts(180);
        end
    endtask

    // The receiver stops for a long time while texts keep coming, so the
    // result register stays full and the byte input has to stall.
    task automatic test_output_backpressure();
        int i;
        source_lazy = 1'b0;
        sink_lazy   = 1'b0;
        hold_off_cycles = 400;
        for (i = 0; i < 12; i++) begin
            make_money_text();
            send_draft();
        end
    endtask

    task automatic test_drain_pause();
        int i;
        for (i = 0; i < 8; i++) begin
            source_lazy = $urandom_range(0, 1);
            sink_lazy   = $urandom_range(0, 1);
            make_money_text();
            send_draft();
            wait_results_drained();
        end
    endtask

    initial begin
        int stall;
        result_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_cycles > 0) begin
                result_bus.ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
            end
            stall = sink_lazy ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!result_bus.valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        money_result_t want;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            if (awaited_amounts.size() == 0) begin
                $error("unexpected result: amount %0d, status %0d",
                       $signed(result_bus.amount), result_bus.status);
                fail_count++;
            end else begin
                want = awaited_amounts.pop_front();
                if (result_bus.amount !== want.amount) begin
                    $error("amount: expected %0d, actual %0d",
                           $signed(want.amount), $signed(result_bus.amount));
                    fail_count++;
                end
                if (result_bus.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, result_bus.status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        char_bus.valid     <= 1'b0;
        char_bus.char_code <= CH_NUL;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.index      <= CFG_FRAC_DIGITS;
        cfg_bus.data       <= '0;
        cf_frac       = FRAC_DEFAULT;
        cf_decimal    = CH_DOT;
        cf_group      = CH_COMMA;
        cf_plus       = CH_PLUS;
        cf_cur_text   = 32'(CH_DOLLAR);
        cf_cur_len    = 3'd1;
        cf_minus_text = 32'(CH_MINUS);
        cf_minus_len  = 3'd1;
        clear_parse();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_defaults();
        test_register_settings();
        test_output_backpressure();
        test_drain_pause();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
